// ===== hw/rtl/swsfr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the single-wire sensor frame receiver: transaction payload types,
// phase and status codes, and the pulse-end decision function. No dependencies.
package swsfr_pkg;

  localparam int FRAME_BITS = 40;
  localparam int BYTE_BITS  = 8;
  localparam int TICK_W     = 16;
  localparam int INDEX_W    = 6;

  // Configuration register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_START_LOW  = 2'd0;
  localparam logic [1:0] REG_START_HIGH = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;

  localparam logic [TICK_W-1:0] START_LOW_RESET  = 16'd1100;
  localparam logic [TICK_W-1:0] START_HIGH_RESET = 16'd40;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET    = 16'd200;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_START_LOW  = 3'd1,
    PH_START_HIGH = 3'd2,
    PH_ACK_LOW    = 3'd3,
    PH_ACK_HIGH   = 3'd4,
    PH_BIT_LOW    = 3'd5,
    PH_BIT_HIGH   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_START_FAIL = 2'd1,
    ST_TIMEOUT    = 2'd2,
    ST_CHECKSUM   = 2'd3
  } status_t;

  typedef struct packed {
    logic start_request;
    logic line_level;
  } sample_t;

  typedef struct packed {
    logic              drive_low;
    logic              drive_high;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [TICK_W-1:0] humidity_raw;
    logic [TICK_W-1:0] temperature_raw;
  } result_t;

  // Measurement state that a pulse end can change.
  typedef struct packed {
    phase_t                phase;
    logic [TICK_W-1:0]     low_length;
    logic                  ack_failed;
    logic [INDEX_W-1:0]    bit_index;
    logic [FRAME_BITS-1:0] frame_bits;
  } meas_t;

  // Completion report of a reading.
  typedef struct packed {
    logic              done;
    status_t           status;
    logic [TICK_W-1:0] hum;
    logic [TICK_W-1:0] temp;
  } fin_t;

  typedef struct packed {
    meas_t m;
    fin_t  f;
  } pulse_res_t;

  // Applies the end of one measured pulse of length len to the measurement state.
  function automatic pulse_res_t end_pulse(meas_t cur, logic [TICK_W-1:0] len,
                                           logic [TICK_W-1:0] tmo);
    pulse_res_t            r;
    logic                  timed;
    logic                  bitv;
    logic [INDEX_W-1:0]    idx;
    logic [FRAME_BITS-1:0] fr;
    logic [BYTE_BITS-1:0]  sum;
    r       = '{m: cur, f: '{done: 1'b0, status: ST_OK, hum: '0, temp: '0}};
    timed   = (len >= tmo);
    bitv    = (cur.low_length < len);
    idx     = cur.bit_index + INDEX_W'(1);
    fr      = {cur.frame_bits[FRAME_BITS-2:0], bitv};
    sum     = fr[4*BYTE_BITS +: BYTE_BITS] + fr[3*BYTE_BITS +: BYTE_BITS]
            + fr[2*BYTE_BITS +: BYTE_BITS] + fr[BYTE_BITS +: BYTE_BITS];
    case (cur.phase)
      PH_ACK_LOW: begin
        if (timed) begin
          r.m.ack_failed = 1'b1;
        end
        r.m.phase = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        if (timed) begin
          r.m.ack_failed = 1'b1;
        end
        if (timed || cur.ack_failed) begin
          r.m.phase  = PH_IDLE;
          r.f.done   = 1'b1;
          r.f.status = ST_START_FAIL;
        end else begin
          r.m.phase      = PH_BIT_LOW;
          r.m.bit_index  = '0;
          r.m.frame_bits = '0;
        end
      end
      PH_BIT_LOW: begin
        r.m.low_length = len;
        r.m.phase      = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        r.m.frame_bits = fr;
        if (timed || (cur.low_length >= tmo)) begin
          r.m.phase  = PH_IDLE;
          r.f.done   = 1'b1;
          r.f.status = ST_TIMEOUT;
        end else begin
          r.m.bit_index = idx;
          if (idx >= INDEX_W'(FRAME_BITS)) begin
            r.m.phase = PH_IDLE;
            r.f.done  = 1'b1;
            if (sum != fr[BYTE_BITS-1:0]) begin
              r.f.status = ST_CHECKSUM;
            end else begin
              r.f.status = ST_OK;
              r.f.hum    = fr[3*BYTE_BITS +: 2*BYTE_BITS];
              r.f.temp   = fr[BYTE_BITS +: 2*BYTE_BITS];
            end
          end else begin
            r.m.phase = PH_BIT_LOW;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/single_wire_sensor_frame_receiver.sv =====
`timescale 1ns / 1ps
// Top level of the single-wire sensor frame receiver: one line sample in, one
// result out per transaction, plus an APB-style register port. Depends on swsfr_pkg.
//
//   Channel   | Handshake                          | Payload
//   ----------+------------------------------------+-------------------------------
//   sample    | sample_valid / sample_ready        | sample_t: request, line level
//   result    | result_valid / result_ready        | result_t: drive, status, words
//   registers | psel, penable, pwrite, pready      | paddr[3:2] index, pwdata/prdata
//
// Every sample transaction is one tick and yields exactly one result transaction.
// The work of a tick is done in the cycle the sample is accepted and lands in the
// result register, so a new sample is taken every cycle while results drain; the
// rate is one transaction per cycle, bounded only by the result register.
// A stalled result holds the register and stops further samples until it is taken.
// Synchronous reset restores the register defaults and returns the reader to idle.
module single_wire_sensor_frame_receiver (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  swsfr_pkg::sample_t      sample,
  output logic                    result_valid,
  input  logic                    result_ready,
  output swsfr_pkg::result_t      result,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import swsfr_pkg::*;

  // Configuration registers.
  logic [TICK_W-1:0] start_low_ticks;
  logic [TICK_W-1:0] start_high_ticks;
  logic [TICK_W-1:0] timeout_ticks;

  // Reader state.
  meas_t             meas;
  meas_t             meas_next;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tick_count_next;
  result_t           result_next;

  // State as seen after a start request has been taken in this tick.
  meas_t             m0;
  logic [TICK_W-1:0] tc0;
  logic              starting;

  logic              accept;
  logic              cfg_write;

  // Pulse-end evaluation, chained for the case where one sample ends two pulses.
  pulse_res_t        pe1;
  pulse_res_t        pe2;
  logic [TICK_W-1:0] tc_inc;
  logic              want_level;
  logic              level_match;
  fin_t              fin;
  logic              drive_low;
  logic              drive_high;

  assign pready       = 1'b1;
  assign sample_ready = !result_valid || result_ready;
  assign accept       = sample_valid && sample_ready;
  assign cfg_write    = psel && penable && pwrite && pready;

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_START_LOW:  prdata = {16'd0, start_low_ticks};
      REG_START_HIGH: prdata = {16'd0, start_high_ticks};
      REG_TIMEOUT:    prdata = {16'd0, timeout_ticks};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_low_ticks  <= START_LOW_RESET;
      start_high_ticks <= START_HIGH_RESET;
      timeout_ticks    <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_START_LOW:  start_low_ticks  <= pwdata[TICK_W-1:0];
        REG_START_HIGH: start_high_ticks <= pwdata[TICK_W-1:0];
        REG_TIMEOUT:    timeout_ticks    <= pwdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A request while idle moves straight into the start-low phase, and that very
  // tick already drives the line low and counts.
  always_comb begin
    starting = (meas.phase == PH_IDLE) && sample.start_request;
    m0       = meas;
    tc0      = tick_count;
    if (starting) begin
      m0.phase      = PH_START_LOW;
      m0.ack_failed = 1'b0;
      tc0           = '0;
    end
  end

  // Line drive for this tick, from the phase the tick runs in.
  always_comb begin
    drive_low  = (m0.phase == PH_START_LOW);
    drive_high = (m0.phase == PH_START_HIGH);
  end

  // A pulse is measured while the line sits at the level the phase waits for. It
  // ends either when it reaches the timeout or when the level changes; in the
  // latter case the changing sample is the first tick of the next pulse, which with
  // a timeout of one or less ends that pulse as well.
  assign tc_inc      = tc0 + TICK_W'(1);
  assign want_level  = (m0.phase == PH_ACK_HIGH) || (m0.phase == PH_BIT_HIGH);
  assign level_match = (sample.line_level == want_level);
  assign pe1 = end_pulse(m0, level_match ? tc_inc : tc0, timeout_ticks);
  assign pe2 = end_pulse(pe1.m, TICK_W'(1), timeout_ticks);

  // Next state of the reader.
  always_comb begin
    meas_next       = m0;
    tick_count_next = tc0;
    fin             = '{done: 1'b0, status: ST_OK, hum: '0, temp: '0};
    case (m0.phase)
      PH_START_LOW: begin
        if (tc_inc >= start_low_ticks) begin
          meas_next.phase = PH_START_HIGH;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_START_HIGH: begin
        if (tc_inc >= start_high_ticks) begin
          meas_next.phase = PH_ACK_LOW;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_ACK_LOW, PH_ACK_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
        if (level_match) begin
          if (tc_inc >= timeout_ticks) begin
            meas_next       = pe1.m;
            fin             = pe1.f;
            tick_count_next = '0;
          end else begin
            tick_count_next = tc_inc;
          end
        end else if (pe1.f.done) begin
          meas_next       = pe1.m;
          fin             = pe1.f;
          tick_count_next = '0;
        end else if (timeout_ticks <= TICK_W'(1)) begin
          meas_next       = pe2.m;
          fin             = pe2.f;
          tick_count_next = '0;
        end else begin
          meas_next       = pe1.m;
          tick_count_next = TICK_W'(1);
        end
      end
      default: begin
        meas_next.phase = PH_IDLE;
      end
    endcase
  end

  // Result of this tick.
  always_comb begin
    result_next.drive_low       = drive_low;
    result_next.drive_high      = drive_high;
    result_next.busy_res        = (meas_next.phase != PH_IDLE) && !fin.done;
    result_next.done_res        = fin.done;
    result_next.status          = fin.status;
    result_next.humidity_raw    = fin.hum;
    result_next.temperature_raw = fin.temp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas         <= '{phase: PH_IDLE, low_length: '0, ack_failed: 1'b0,
                        bit_index: '0, frame_bits: '0};
      tick_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        meas         <= meas_next;
        tick_count   <= tick_count_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the single-wire sensor frame receiver: drives line
// samples and register writes, predicts every result transaction and compares it.
// Depends on swsfr_pkg and single_wire_sensor_frame_receiver.
module testbench;
  import swsfr_pkg::*;

  // A correct run is a little under two thousand line samples; the limit leaves room even
  // if every sample met the longest gap and the longest result stall.
  localparam int CYCLE_LIMIT = 250000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  sample_t     sample_data = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  single_wire_sensor_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Our own copy of the reader: register values and measurement state, updated once
  // for every sample transaction that the block accepts.
  logic [15:0] cfg_start_low  = START_LOW_RESET;
  logic [15:0] cfg_start_high = START_HIGH_RESET;
  logic [15:0] cfg_timeout    = TIMEOUT_RESET;
  phase_t      rd_phase       = PH_IDLE;
  logic [15:0] rd_ticks       = '0;
  logic [15:0] rd_low_len     = '0;
  logic        rd_ack_bad     = 1'b0;
  logic [5:0]  rd_bit_idx     = '0;
  logic [39:0] rd_frame       = '0;
  result_t     tick_out;

  // Results that the block owes us, oldest first, and the run's bookkeeping.
  result_t pending_results[$];
  int      mismatch_count = 0;
  int      samples_sent   = 0;
  int      readings_seen [4] = '{0, 0, 0, 0};
  int      cycle_count    = 0;
  bit      idle_on        = 1'b1;

  function automatic void finish_reading(input status_t st);
    rd_phase          = PH_IDLE;
    rd_ticks          = '0;
    tick_out.done_res = 1'b1;
    tick_out.status   = st;
  endfunction

  // A pulse of length len has just ended: move the reader on. A pulse counts as timed
  // out once it reaches the timeout, and a bit is a one when its low part is shorter.
  function automatic void close_pulse(input logic [15:0] len);
    logic       timed;
    logic [7:0] sum;
    timed = (len >= cfg_timeout);
    case (rd_phase)
      PH_ACK_LOW: begin
        if (timed) rd_ack_bad = 1'b1;
        rd_phase = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        if (timed) rd_ack_bad = 1'b1;
        if (rd_ack_bad) begin
          finish_reading(ST_START_FAIL);
        end else begin
          rd_phase   = PH_BIT_LOW;
          rd_bit_idx = '0;
          rd_frame   = '0;
        end
      end
      PH_BIT_LOW: begin
        rd_low_len = len;
        rd_phase   = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        rd_frame = {rd_frame[38:0], rd_low_len < len};
        // A timeout on either half of a bit, the last one included, ends the reading.
        if (timed || rd_low_len >= cfg_timeout) begin
          finish_reading(ST_TIMEOUT);
        end else begin
          rd_bit_idx = rd_bit_idx + 6'd1;
          if (rd_bit_idx >= 6'(FRAME_BITS)) begin
            sum = rd_frame[39:32] + rd_frame[31:24] + rd_frame[23:16] + rd_frame[15:8];
            if (sum != rd_frame[7:0]) begin
              finish_reading(ST_CHECKSUM);
            end else begin
              tick_out.humidity_raw    = rd_frame[39:24];
              tick_out.temperature_raw = rd_frame[23:8];
              finish_reading(ST_OK);
            end
          end else begin
            rd_phase = PH_BIT_LOW;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Works out the result of one tick and advances the reader by that tick.
  function automatic result_t predict_tick(input sample_t s);
    logic want_lvl;
    tick_out = '0;
    // A request is only taken while idle; the accepting tick already drives low.
    if (rd_phase == PH_IDLE && s.start_request) begin
      rd_phase   = PH_START_LOW;
      rd_ticks   = '0;
      rd_ack_bad = 1'b0;
    end
    case (rd_phase)
      PH_START_LOW: begin
        tick_out.drive_low = 1'b1;
        rd_ticks = rd_ticks + 16'd1;
        if (rd_ticks >= cfg_start_low) begin
          rd_phase = PH_START_HIGH;
          rd_ticks = '0;
        end
      end
      PH_START_HIGH: begin
        tick_out.drive_high = 1'b1;
        rd_ticks = rd_ticks + 16'd1;
        if (rd_ticks >= cfg_start_high) begin
          rd_phase = PH_ACK_LOW;
          rd_ticks = '0;
        end
      end
      PH_ACK_LOW, PH_ACK_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
        want_lvl = (rd_phase == PH_ACK_HIGH || rd_phase == PH_BIT_HIGH);
        if (s.line_level == want_lvl) begin
          rd_ticks = rd_ticks + 16'd1;
          if (rd_ticks >= cfg_timeout) begin
            close_pulse(rd_ticks);
            rd_ticks = '0;
          end
        end else begin
          // The sample that ends a pulse is the first sample of the next one, and
          // with a timeout of one it can end that pulse straight away as well.
          close_pulse(rd_ticks);
          if (rd_phase != PH_IDLE) begin
            rd_ticks = 16'd1;
            if (rd_ticks >= cfg_timeout) begin
              close_pulse(rd_ticks);
              rd_ticks = '0;
            end
          end else begin
            rd_ticks = '0;
          end
        end
      end
      default: begin
      end
    endcase
    tick_out.busy_res = (rd_phase != PH_IDLE) && !tick_out.done_res;
    return tick_out;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in %s at sample %0d: expected %0h, got %0h",
                 name, samples_sent, want, got);
      end
    end
  endfunction

  // Result side: every accepted result transaction is held against the oldest
  // prediction. Handshake signals are read at the edge, before any update lands.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result transaction with nothing expected: %h", result_data);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("drive_low", 16'(want.drive_low), 16'(result_data.drive_low));
        check_field("drive_high", 16'(want.drive_high), 16'(result_data.drive_high));
        check_field("busy_res", 16'(want.busy_res), 16'(result_data.busy_res));
        check_field("done_res", 16'(want.done_res), 16'(result_data.done_res));
        check_field("status", 16'(want.status), 16'(result_data.status));
        check_field("humidity_raw", want.humidity_raw, result_data.humidity_raw);
        check_field("temperature_raw", want.temperature_raw, result_data.temperature_raw);
        if (want.done_res) readings_seen[want.status]++;
      end
    end
  end

  // The receiver stalls in random bursts while idling is enabled, and otherwise
  // takes every result transaction at once.
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends one line sample. Valid is only lowered for a random gap; otherwise the next
  // transaction follows straight on, and the prediction is made on acceptance.
  task automatic send_sample(input logic req, input logic lvl);
    sample_t s;
    s.start_request = req;
    s.line_level    = lvl;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data  <= s;
    do @(posedge clk); while (!sample_ready);
    pending_results.push_back(predict_tick(s));
    samples_sent++;
  endtask

  // Holds the sender off until every predicted result has been taken; the extra
  // cycles cover the result register.
  task automatic wait_for_results();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write over the APB-style port, made only once every predicted result
  // has been taken. The upper data bits are random and must be ignored.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_LOW:  cfg_start_low  = value;
      REG_START_HIGH: cfg_start_high = value;
      REG_TIMEOUT:    cfg_timeout    = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_timing(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] tmo);
    write_reg(REG_START_LOW, lo);
    write_reg(REG_START_HIGH, hi);
    write_reg(REG_TIMEOUT, tmo);
  endtask

  // Toggles the line every tick until any reading in progress has ended; single-tick
  // pulses keep this short whatever the timeout.
  task automatic settle_reader();
    logic lvl;
    lvl = 1'b1;
    while (rd_phase != PH_IDLE) begin
      lvl = ~lvl;
      send_sample(1'b0, lvl);
    end
  endtask

  // A pulse of n ticks at one level, with the odd request thrown in: while a reading
  // is under way these must be ignored.
  task automatic send_level(input logic lvl, input int n);
    repeat (n) send_sample($urandom_range(0, 7) == 0, lvl);
  endtask

  function automatic logic [39:0] make_frame(input logic [7:0] hm, input logic [7:0] hl,
                                             input logic [7:0] tm, input logic [7:0] tl,
                                             input bit corrupt);
    logic [7:0] ck;
    ck = hm + hl + tm + tl;
    if (corrupt) ck = ck ^ 8'($urandom_range(1, 255));
    return {hm, hl, tm, tl, ck};
  endfunction

  function automatic logic [39:0] random_frame(input bit corrupt);
    return make_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), corrupt);
  endfunction

  // A whole reading as a sensor would answer it: request, start pulses (line noise
  // there is ignored), acknowledge low and high, then 40 bits MSB first. Pulse
  // lengths stay at most max_len and below the timeout, the limit never under two, except
  // the pulse numbered long_pulse (0 and 1 acknowledge, then low and high of each bit),
  // which is stretched to the timeout or just past it. A negative long_pulse means none.
  task automatic send_reading(input logic [39:0] word, input int long_pulse,
                              input int max_len);
    int lo;
    int hi;
    int cap;
    int stretch;
    settle_reader();
    cap = int'(cfg_timeout) - 1;
    if (cap > max_len) cap = max_len;
    if (cap < 2) cap = 2;
    stretch = int'(cfg_timeout) + $urandom_range(0, 2);
    if (stretch < 1) stretch = 1;
    send_sample(1'b1, 1'($urandom_range(0, 1)));
    while (rd_phase == PH_START_LOW || rd_phase == PH_START_HIGH) begin
      send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    for (int k = -1; k < FRAME_BITS; k++) begin
      if (k < 0) begin
        lo = $urandom_range(1, cap);
        hi = $urandom_range(1, cap);
      end else if (word[FRAME_BITS-1-k]) begin
        hi = $urandom_range(2, cap);
        lo = $urandom_range(1, hi - 1);
      end else begin
        lo = $urandom_range(1, cap);
        hi = $urandom_range(1, lo);
      end
      if (long_pulse == 2 * k + 2) lo = stretch;
      if (long_pulse == 2 * k + 3) hi = stretch;
      send_level(1'b0, lo);
      send_level(1'b1, hi);
    end
    // The falling edge after the last high pulse completes the frame.
    send_level(1'b0, 1);
  endtask

  // A reading with the timeout still at its reset default; the start lengths are
  // shortened first so that the reading stays brief.
  task automatic test_reset_defaults();
    write_reg(REG_START_LOW, 16'd4);
    write_reg(REG_START_HIGH, 16'd3);
    send_reading(make_frame(8'h02, 8'h8C, 8'h01, 8'h5F, 1'b0), -1, 3);
  endtask

  // All-zero and all-one data, where the checksum wraps.
  task automatic test_data_extremes();
    set_timing(16'd3, 16'd2, 16'd6);
    send_reading(make_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0), -1, 2);
    send_reading(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0), -1, 2);
  endtask

  task automatic test_checksum_error();
    send_reading(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), -1, 2);
  endtask

  // A timed-out acknowledge half still lets the other half be measured, and the
  // reading then ends as a start failure.
  task automatic test_ack_failures();
    send_reading(random_frame(1'b0), 0, 2);
    send_reading(random_frame(1'b0), 1, 2);
  endtask

  // Timeouts on both halves of the last bit.
  task automatic test_bit_timeouts();
    send_reading(random_frame(1'b0), 80, 2);
    send_reading(random_frame(1'b0), 81, 2);
  endtask

  // Zero start lengths act as one, a zero timeout times out every pulse, a timeout
  // of one lets a single sample end two pulses, and the largest timeout never fires.
  task automatic test_register_edges();
    set_timing(16'd0, 16'd0, 16'd0);
    send_reading(random_frame(1'b0), -1, 3);
    set_timing(16'd1, 16'd1, 16'd1);
    send_reading(random_frame(1'b0), -1, 3);
    set_timing(16'd1, 16'd2, 16'd2);
    send_reading(random_frame(1'b0), -1, 3);
    set_timing(16'd2, 16'd1, 16'hFFFF);
    send_reading(random_frame(1'b0), -1, 2);
  endtask

  // Mostly well-formed readings with random data and timing, some with a bad
  // checksum or a stretched pulse, and bursts of line noise with random requests.
  // Registers are changed now and then, with the reader brought back to idle first.
  task automatic test_random_traffic(input int quota);
    int stop_at;
    int pick;
    stop_at = samples_sent + quota;
    while (samples_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        settle_reader();
        set_timing(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                   ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                                : 16'($urandom_range(3, 12)));
      end
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        send_reading(random_frame(1'b0), -1, $urandom_range(2, 4));
      end else if (pick < 14) begin
        send_reading(random_frame(1'b1), -1, $urandom_range(2, 4));
      end else if (pick < 17) begin
        send_reading(random_frame(1'b0), $urandom_range(0, 81), $urandom_range(2, 4));
      end else begin
        repeat ($urandom_range(4, 30)) begin
          send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_data_extremes();
    test_checksum_error();
    test_ack_failures();
    test_bit_timeouts();
    test_register_edges();
    test_random_traffic(150);
    // The closing stretch runs with no gaps and no stalls on either side.
    idle_on = 1'b0;
    test_random_traffic(100);
    wait_for_results();
    repeat (5) @(posedge clk);
    $display("Covered %0d line samples and %0d finished readings: %0d good, %0d start",
             samples_sent, readings_seen[0] + readings_seen[1] + readings_seen[2]
             + readings_seen[3], readings_seen[0], readings_seen[1]);
    $display("failures, %0d timeouts and %0d checksum errors, over many register settings.",
             readings_seen[2], readings_seen[3]);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total.", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
